// ===== rtl/core/btsamp_pkg.sv =====
// Shared types and constants for the bilinear texel sampler.
// Holds the stream word layout, command and register codes and the fixed-point format.
// Depends on nothing; imported by the sampler top level.
package btsamp_pkg;

  // Fixed-point format of the sample coordinates and blend weights.
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = FRAC_BITS + 1;

  // Stream word widths.
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 32;
  localparam int TEXEL_W    = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_HGT_W  = 8;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_IMAGE_WIDTH  = 1'b0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = 1'b1;

  // Command carried on tuser.
  typedef logic cmd_t;

  localparam cmd_t CMD_WRITE  = 1'b0;
  localparam cmd_t CMD_SAMPLE = 1'b1;

endpackage

// ===== rtl/core/bilinear_texel_sampler_wrap_clamp.sv =====
// Bilinear RGBA8 texel sampler: two row-parity banks of texel memory and a five-stage pipeline.
// Depends on btsamp_pkg for the word layout, codes and fixed-point format.
// A sample word passes stages 1 to 4 and the output register before it shows on out_tvalid.
// Throughput: one word per cycle, writes and samples alike, barring backpressure; each bank serves two reads a cycle.
// Reset: synchronous, active low; clears the pipeline valid bits and sets the sizes to the
// largest image (at most 256x128); texel memory is not cleared and holds nothing useful until written.
module bilinear_texel_sampler_wrap_clamp
  import btsamp_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // texel_x[7:0], texel_y[14:8], red_in[22:15], green_in[30:23], blue_in[38:31],
  // alpha_in[46:39], u_coord[63:47], v_coord[80:64], zero fill [87:81]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int RW    = (YW > 1) ? YW - 1 : 1;
  localparam int AW    = RW + XW;
  localparam int DEPTH = 1 << AW;
  localparam int SUW   = COORD_W + WW;
  localparam int SVW   = COORD_W + HW;
  localparam int XIW   = WW + 1;
  localparam int YIW   = HW + 1;
  localparam int LW    = 8 + FRAC_BITS;
  localparam int CWW   = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
  localparam int CHW   = (HW > CFG_HGT_W) ? HW : CFG_HGT_W;
  localparam int RST_W = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int RST_H = (MAX_HEIGHT < 128) ? MAX_HEIGHT : 128;

  // Row blend: a*(1-t) + b*t, exact in Q8.F.
  function automatic logic [LW-1:0] lerp_h(input logic [7:0] a, input logic [7:0] b,
                                           input logic [FRAC_BITS-1:0] t);
    logic signed [8:0]           d;
    logic signed [FRAC_BITS+9:0] p;
    logic signed [FRAC_BITS+9:0] s;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, t});
    s = $signed({2'b00, a, {FRAC_BITS{1'b0}}}) + p;
    return s[LW-1:0];
  endfunction

  // Column blend of two row results, rounded half up to a byte.
  function automatic logic [7:0] lerp_v(input logic [LW-1:0] a, input logic [LW-1:0] b,
                                        input logic [FRAC_BITS-1:0] t);
    logic signed [LW:0]              d;
    logic signed [2*FRAC_BITS+9:0]   rnd;
    logic signed [2*FRAC_BITS+9:0]   s;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    rnd = '0;
    rnd[2*FRAC_BITS-1] = 1'b1;
    s = $signed({2'b00, a, {FRAC_BITS{1'b0}}}) + d * $signed({1'b0, t}) + rnd;
    return s[2*FRAC_BITS+7:2*FRAC_BITS];
  endfunction

  // Input word fields.
  logic [7:0]         in_texel_x;
  logic [6:0]         in_texel_y;
  logic [TEXEL_W-1:0] in_texel;
  logic [COORD_W-1:0] in_u_coord;
  logic [COORD_W-1:0] in_v_coord;

  assign in_texel_x = in_tdata[7:0];
  assign in_texel_y = in_tdata[14:8];
  assign in_texel   = in_tdata[46:15];
  assign in_u_coord = in_tdata[63:47];
  assign in_v_coord = in_tdata[80:64];

  // Sizes in use, stored already clamped to [1, max].
  logic [WW-1:0] image_width_r;
  logic [HW-1:0] image_height_r;
  logic [WW-1:0] image_width_nxt;
  logic [HW-1:0] image_height_nxt;

  always_comb begin
    image_width_nxt  = image_width_r;
    image_height_nxt = image_height_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          if (cfg_wdata == '0) begin
            image_width_nxt = WW'(1);
          end else if (CWW'(cfg_wdata) > CWW'(MAX_WIDTH)) begin
            image_width_nxt = WW'(MAX_WIDTH);
          end else begin
            image_width_nxt = WW'(cfg_wdata);
          end
        end
        CFG_IMAGE_HEIGHT: begin
          if (cfg_wdata[CFG_HGT_W-1:0] == '0) begin
            image_height_nxt = HW'(1);
          end else if (CHW'(cfg_wdata[CFG_HGT_W-1:0]) > CHW'(MAX_HEIGHT)) begin
            image_height_nxt = HW'(MAX_HEIGHT);
          end else begin
            image_height_nxt = HW'(cfg_wdata[CFG_HGT_W-1:0]);
          end
        end
        default: begin
          image_width_nxt  = image_width_r;
          image_height_nxt = image_height_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WW'(RST_W);
      image_height_r <= HW'(RST_H);
    end else begin
      image_width_r  <= image_width_nxt;
      image_height_r <= image_height_nxt;
    end
  end

  // Pipeline valid bits and the backpressure chain from the output register.
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  cmd_t s1_cmd_r, s2_cmd_r;
  logic rdy_out, rdy4, rdy3, rdy2, rdy1;

  assign rdy_out   = !out_valid_r || out_tready;
  assign rdy4      = !s4_valid_r || rdy_out;
  assign rdy3      = !s3_valid_r || rdy4;
  assign rdy2      = !s2_valid_r || (s2_cmd_r != CMD_SAMPLE) || rdy3;
  assign rdy1      = !s1_valid_r || rdy2;
  assign in_tready = rdy1;

  // Stage 1: scale the coordinates by the image size, add half a texel.
  logic [7:0]           s1_x_r;
  logic [6:0]           s1_y_r;
  logic [TEXEL_W-1:0]   s1_texel_r;
  logic [XIW-1:0]       s1_xi_r;
  logic [YIW-1:0]       s1_yi_r;
  logic [FRAC_BITS-1:0] s1_tx_r, s1_ty_r;
  logic [SUW-1:0]       su;
  logic [SVW-1:0]       sv;

  assign su = SUW'(in_u_coord) * SUW'(image_width_r) + (SUW'(1) << (FRAC_BITS - 1));
  assign sv = SVW'(in_v_coord) * SVW'(image_height_r) + (SVW'(1) << (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (rdy1) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_cmd_r   <= in_tuser;
      s1_x_r     <= in_texel_x;
      s1_y_r     <= in_texel_y;
      s1_texel_r <= in_texel;
      s1_xi_r    <= su[SUW-1:FRAC_BITS];
      s1_tx_r    <= su[FRAC_BITS-1:0];
      s1_yi_r    <= sv[SVW-1:FRAC_BITS];
      s1_ty_r    <= sv[FRAC_BITS-1:0];
    end
  end

  // Stage 2 logic: wrap columns, clamp rows, form the write address.
  logic [XIW-1:0] xb_full;
  logic [XW-1:0]  xa_nxt, xb_nxt;
  logic [YW-1:0]  ya_nxt, yb_nxt;
  logic [YW-1:0]  wr_row;
  logic           wr_ok_nxt;

  always_comb begin
    if (s1_xi_r >= (XIW'(image_width_r) << 1)) begin
      xb_full = s1_xi_r - (XIW'(image_width_r) << 1);
    end else if (s1_xi_r >= XIW'(image_width_r)) begin
      xb_full = s1_xi_r - XIW'(image_width_r);
    end else begin
      xb_full = s1_xi_r;
    end
    xb_nxt = XW'(xb_full);
    if (xb_full == '0) begin
      xa_nxt = XW'(image_width_r - WW'(1));
    end else begin
      xa_nxt = XW'(xb_full - XIW'(1));
    end

    if (s1_yi_r >= YIW'(image_height_r)) begin
      yb_nxt = YW'(image_height_r - HW'(1));
    end else begin
      yb_nxt = YW'(s1_yi_r);
    end
    if (s1_yi_r > YIW'(image_height_r)) begin
      ya_nxt = YW'(image_height_r - HW'(1));
    end else if (s1_yi_r == '0) begin
      ya_nxt = '0;
    end else begin
      ya_nxt = YW'(s1_yi_r - YIW'(1));
    end

    wr_row    = YW'(s1_y_r);
    wr_ok_nxt = (32'(s1_x_r) < MAX_WIDTH) && (32'(s1_y_r) < MAX_HEIGHT);
  end

  logic                 s2_wr_ok_r;
  logic                 s2_wr_bank_r;
  logic [AW-1:0]        s2_wr_addr_r;
  logic [TEXEL_W-1:0]   s2_texel_r;
  logic [XW-1:0]        s2_xa_r, s2_xb_r;
  logic [YW-1:0]        s2_ya_r, s2_yb_r;
  logic [FRAC_BITS-1:0] s2_tx_r, s2_ty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (rdy2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_cmd_r     <= s1_cmd_r;
      s2_wr_ok_r   <= wr_ok_nxt;
      s2_wr_bank_r <= wr_row[0];
      s2_wr_addr_r <= {RW'(wr_row >> 1), XW'(s1_x_r)};
      s2_texel_r   <= s1_texel_r;
      s2_xa_r      <= xa_nxt;
      s2_xb_r      <= xb_nxt;
      s2_ya_r      <= ya_nxt;
      s2_yb_r      <= yb_nxt;
      s2_tx_r      <= s1_tx_r;
      s2_ty_r      <= s1_ty_r;
    end
  end

  // Texel memory: even rows in bank 0, odd rows in bank 1. The two rows of a
  // sample are adjacent (or the same), so each bank reads the left and right
  // columns of one row. Writes and reads happen in the same stage, in order.
  logic               mem_we;
  logic [TEXEL_W-1:0] bank_rd_a [2];
  logic [TEXEL_W-1:0] bank_rd_b [2];

  assign mem_we = s2_valid_r && (s2_cmd_r == CMD_WRITE) && s2_wr_ok_r;

  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic [TEXEL_W-1:0] mem [DEPTH];
    logic [TEXEL_W-1:0] rd_a_r, rd_b_r;
    logic [YW-1:0]      row;
    logic [AW-1:0]      addr_a, addr_b;

    assign row    = (s2_ya_r[0] == 1'(b)) ? s2_ya_r : s2_yb_r;
    assign addr_a = {RW'(row >> 1), s2_xa_r};
    assign addr_b = {RW'(row >> 1), s2_xb_r};

    always_ff @(posedge clk) begin
      if (mem_we && (s2_wr_bank_r == 1'(b))) begin
        mem[s2_wr_addr_r] <= s2_texel_r;
      end
      if (rdy3) begin
        rd_a_r <= mem[addr_a];
        rd_b_r <= mem[addr_b];
      end
    end

    assign bank_rd_a[b] = rd_a_r;
    assign bank_rd_b[b] = rd_b_r;
  end

  // Stage 3: texels arrive; remember which bank holds the top and bottom rows.
  logic                 s3_top_bank_r, s3_bot_bank_r;
  logic [FRAC_BITS-1:0] s3_tx_r, s3_ty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (rdy3) begin
      s3_valid_r <= s2_valid_r && (s2_cmd_r == CMD_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_top_bank_r <= s2_ya_r[0];
      s3_bot_bank_r <= s2_yb_r[0];
      s3_tx_r       <= s2_tx_r;
      s3_ty_r       <= s2_ty_r;
    end
  end

  // Horizontal blends of the top and bottom rows, four channels each.
  logic [TEXEL_W-1:0] top_a, top_b, bot_a, bot_b;
  logic [LW-1:0]      top_nxt [4];
  logic [LW-1:0]      bot_nxt [4];

  always_comb begin
    top_a = bank_rd_a[s3_top_bank_r];
    top_b = bank_rd_b[s3_top_bank_r];
    bot_a = bank_rd_a[s3_bot_bank_r];
    bot_b = bank_rd_b[s3_bot_bank_r];
    for (int ch = 0; ch < 4; ch++) begin
      top_nxt[ch] = lerp_h(top_a[8*ch +: 8], top_b[8*ch +: 8], s3_tx_r);
      bot_nxt[ch] = lerp_h(bot_a[8*ch +: 8], bot_b[8*ch +: 8], s3_tx_r);
    end
  end

  // Stage 4: row results.
  logic [LW-1:0]        s4_top_r [4];
  logic [LW-1:0]        s4_bot_r [4];
  logic [FRAC_BITS-1:0] s4_ty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (rdy4) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_top_r <= top_nxt;
      s4_bot_r <= bot_nxt;
      s4_ty_r  <= s3_ty_r;
    end
  end

  // Vertical blend and rounding into the output register.
  logic [OUT_DATA_W-1:0] out_data_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      out_data_nxt[8*ch +: 8] = lerp_v(s4_top_r[ch], s4_bot_r[ch], s4_ty_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
